// ===== rtl/hchk_pkg.sv =====
// ----------------------------------------------------------------------------
// hchk_pkg: shared types and constants for the chunked body decoder
// Byte codes, phase and result codes, payload structs and character classes.
// ----------------------------------------------------------------------------
package hchk_pkg;

  localparam int unsigned COUNT_WIDTH      = 32;
  localparam int unsigned SIZE_WIDTH       = 64;
  localparam int unsigned BYTE_COUNT_WIDTH = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PH_SIZE   = 3'd0,
    PH_EXT    = 3'd1,
    PH_DATA   = 3'd2,
    PH_TERM   = 3'd3,
    PH_TNAME  = 3'd4,
    PH_TVALUE = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_EARLY_END = 2'd1,
    ERR_MALFORMED = 2'd2
  } err_e;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_END  = 1'b1
  } mode_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } hchk_item_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [7:0]                  body_byte;
    logic [1:0]                  error_code;
    logic [BYTE_COUNT_WIDTH-1:0] byte_count;
  } hchk_res_t;

  // Per-line scratch flags, cleared at every accepted line end but the final empty line
  typedef struct packed {
    logic digit_seen;
    logic blank_seen;
    logic bad;
    logic nonempty;
    logic pending_cr;
  } hchk_line_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) r = {1'b1, 4'(b - 8'h30)};
    else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
    else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic token_char(input logic [7:0] b);
    return (b inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39],
                      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e});
  endfunction

endpackage

// ===== rtl/hchk_if.sv =====
// ----------------------------------------------------------------------------
// hchk_if: item channels of the chunked body decoder
// Valid/ready channels for raw input items and decoded result items.
// ----------------------------------------------------------------------------
interface hchk_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface hchk_out_if;
  import hchk_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [7:0]                  body_byte;
  logic [1:0]                  error_code;
  logic [BYTE_COUNT_WIDTH-1:0] byte_count;

  modport source (output valid, output kind, output body_byte, output error_code,
                  output byte_count, input ready);
  modport sink (input valid, input kind, input body_byte, input error_code,
                input byte_count, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// An accepted input item passes the input register, then the decode step, then
// the result register before its result is valid at the output. Throughput: one
// input item per cycle while the result register has room; each byte is one
// short decode step. Both registers keep the pipe full while the sink stalls.
// Reset (rst_ni low, asynchronous) returns to the start of a chunk size line
// with both byte counters at zero; both registers come out of reset empty.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer body decoder
// Passes chunk data bytes out and reports message end or framing failure.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  hchk_in_if.sink    in_i,
  hchk_out_if.source out_o
);
  import hchk_pkg::*;

  hchk_item_t item_in;
  hchk_item_t item_q;
  logic       item_valid;
  logic       take;
  logic       out_free;
  logic       res_valid;
  hchk_res_t  res;
  hchk_res_t  res_q;

  // Pack the incoming item
  assign item_in.mode      = in_i.mode;
  assign item_in.data_byte = in_i.data_byte;

  // Advance the held item whenever the result register has room for its result
  assign take = item_valid && out_free;

  hchk_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (item_in),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item_q)
  );

  // Framing state: size line, chunk data, terminator, trailer lines
  hchk_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item_q),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold results here; items that produce no result simply drop out
  hchk_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res_q)
  );

  assign out_o.kind       = res_q.kind;
  assign out_o.body_byte  = res_q.body_byte;
  assign out_o.error_code = res_q.error_code;
  assign out_o.byte_count = res_q.byte_count;

endmodule

// ===== rtl/hchk_in_reg.sv =====
// ----------------------------------------------------------------------------
// hchk_in_reg: input item register
// Holds one item for the decode step; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module hchk_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  hchk_pkg::hchk_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output hchk_pkg::hchk_item_t item_o
);
  import hchk_pkg::*;

  logic       valid_q;
  hchk_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/hchk_core.sv =====
// ----------------------------------------------------------------------------
// hchk_core: chunked framing state and per-byte decode step
// Updates the framing state for one item and forms its result, if any.
// ----------------------------------------------------------------------------
module hchk_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  hchk_pkg::hchk_item_t item_i,
  input  logic                 take_i,
  output logic                 res_valid_o,
  output hchk_pkg::hchk_res_t  res_o
);
  import hchk_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [SIZE_WIDTH-1:0]  size_q, size_d;
  hchk_line_t             line_q, line_d;
  logic [COUNT_WIDTH-1:0] consumed_q, consumed_d;
  logic [COUNT_WIDTH-1:0] boundary_q, boundary_d;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [4:0]             hv;
  logic [7:0]             b;
  logic                   fail_req;
  err_e                   fail_err;
  logic                   done_req;

  assign b       = item_i.data_byte;
  assign hv      = hex_value(b);
  assign cnt_inc = (consumed_q == COUNT_MAX) ? consumed_q : consumed_q + COUNT_WIDTH'(1);

  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    line_d      = line_q;
    consumed_d  = consumed_q;
    boundary_d  = boundary_q;
    fail_req    = 1'b0;
    fail_err    = ERR_MALFORMED;
    done_req    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (valid_i && phase_q != PH_DONE) begin
      if (item_i.mode == MODE_END) begin
        fail_req = 1'b1;
        fail_err = ERR_EARLY_END;
      end else begin
        consumed_d = cnt_inc;
        if (phase_q == PH_DATA) begin
          size_d = size_q - SIZE_WIDTH'(1);
          if (size_q == SIZE_WIDTH'(1)) begin
            line_d  = '0;
            phase_d = PH_TERM;
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.body_byte = b;
        end else if (line_q.pending_cr) begin
          if (b != CH_LF) begin
            fail_req = 1'b1;
          end else begin
            line_d.pending_cr = 1'b0;
            case (phase_q)
              PH_SIZE, PH_EXT: begin
                if (line_q.bad || !line_q.digit_seen) begin
                  fail_req = 1'b1;
                end else begin
                  line_d  = '0;
                  phase_d = (size_q == '0) ? PH_TNAME : PH_DATA;
                end
              end
              PH_TERM: begin
                if (line_q.nonempty) begin
                  fail_req = 1'b1;
                end else begin
                  boundary_d = cnt_inc;
                  line_d     = '0;
                  size_d     = '0;
                  phase_d    = PH_SIZE;
                end
              end
              PH_TNAME: begin
                if (line_q.nonempty) fail_req = 1'b1;
                else done_req = 1'b1;
              end
              default: begin
                if (line_q.bad) begin
                  fail_req = 1'b1;
                end else begin
                  line_d  = '0;
                  phase_d = PH_TNAME;
                end
              end
            endcase
          end
        end else if (b == CH_CR) begin
          line_d.pending_cr = 1'b1;
        end else begin
          case (phase_q)
            PH_SIZE: begin
              if (b == CH_SEMI) begin
                phase_d = PH_EXT;
              end else if (hv[4]) begin
                // Digit after a blank, or one that would push bits off the top
                if (line_q.blank_seen || size_q[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                  line_d.bad = 1'b1;
                end else begin
                  size_d = {size_q[SIZE_WIDTH-5:0], hv[3:0]};
                end
                line_d.digit_seen = 1'b1;
              end else if (b == CH_SPACE || b == CH_TAB) begin
                if (!line_q.digit_seen) line_d.bad = 1'b1;
                line_d.blank_seen = 1'b1;
              end else begin
                line_d.bad = 1'b1;
              end
            end
            PH_EXT: begin
              line_d = line_q;
            end
            PH_TERM: begin
              line_d.nonempty = 1'b1;
            end
            PH_TNAME: begin
              line_d.nonempty = 1'b1;
              if (b == CH_COLON) begin
                if (!line_q.nonempty) line_d.bad = 1'b1;
                phase_d = PH_TVALUE;
              end else if (!token_char(b)) begin
                line_d.bad = 1'b1;
              end
            end
            default: begin
              if (b == CH_LF || b == CH_NUL) line_d.bad = 1'b1;
            end
          endcase
        end
      end

      if (fail_req) begin
        phase_d          = PH_DONE;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_FAIL;
        res_o.error_code = fail_err;
        res_o.byte_count = BYTE_COUNT_WIDTH'(boundary_q);
      end else if (done_req) begin
        phase_d          = PH_DONE;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_DONE;
        res_o.byte_count = BYTE_COUNT_WIDTH'(cnt_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIZE;
      size_q     <= '0;
      line_q     <= '0;
      consumed_q <= '0;
      boundary_q <= '0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      size_q     <= size_d;
      line_q     <= line_d;
      consumed_q <= consumed_d;
      boundary_q <= boundary_d;
    end
  end

  a_end_result_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_valid_o && res_o.kind != KIND_DATA |=> phase_q == PH_DONE)
    else $error("finished or failed result did not stop the decoder");

  a_quiet_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !res_valid_o)
    else $error("result produced after message end");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> size_q != '0)
    else $error("chunk data phase with nothing remaining");

  a_boundary_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boundary_q <= consumed_q)
    else $error("chunk boundary ahead of consumed count");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> consumed_q >= $past(consumed_q))
    else $error("consumed count went backward");

endmodule

// ===== rtl/hchk_out_reg.sv =====
// ----------------------------------------------------------------------------
// hchk_out_reg: result item register
// Holds one result until taken; accepts a new one in the same cycle.
// ----------------------------------------------------------------------------
module hchk_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hchk_pkg::hchk_res_t res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output hchk_pkg::hchk_res_t res_o
);
  import hchk_pkg::*;

  logic      valid_q;
  hchk_res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== tb/sv/tb_http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder: self-checking bench for the chunked decoder
// Feeds one long chunked message through the input channel and checks every
// result item against a cycle-free decode model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
  import hchk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One byte or end marker waiting to be sent; hold makes the sender wait
  // until every decoded item so far has come back before offering it.
  typedef struct {
    hchk_item_t item;
    bit         hold;
  } pend_item_t;

  logic clk_i;
  logic rst_ni;

  hchk_in_if  in_if ();
  hchk_out_if out_if ();

  http_chunked_body_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Decode model state. The decoder runs a single message per reset, so the
  // whole run is one chunked body that ends in a finish or a failure.
  // --------------------------------------------------------------------------
  phase_e                 ph;
  logic [SIZE_WIDTH-1:0]  remaining;
  hchk_line_t             ln;
  logic [COUNT_WIDTH-1:0] consumed;
  logic [COUNT_WIDTH-1:0] boundary;

  pend_item_t body_q[$];
  hchk_res_t  decoded_q[$];
  pend_item_t pend;
  hchk_res_t  predicted;
  hchk_res_t  want;
  bit         hold_next;
  bit         in_fire;
  int         accepted_cnt;
  int         total_items;
  int         errors;
  int         cycles;
  int         burst_left;
  int         gap_left;
  int         stall_left;
  int unsigned rdy_cycle;

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  // Header name characters; punctuation given in hex to keep quotes and
  // backticks out of string literals
  function automatic bit is_tchar(input logic [7:0] b);
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
      return 1'b1;
    case (b)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit fail_with(input err_e err, output hchk_res_t r);
    ph           = PH_DONE;
    r            = '0;
    r.kind       = KIND_FAIL;
    r.error_code = err;
    r.byte_count = boundary;
    return 1'b1;
  endfunction

  // Advance the decode model by one accepted item; return 1 with r filled
  // when the item yields a result item.
  function automatic bit chunk_decode_step(input hchk_item_t it, output hchk_res_t r);
    logic [7:0] b;
    int         hv;
    b = it.data_byte;
    r = '0;
    if (ph == PH_DONE) return 1'b0;
    if (it.mode == MODE_END) return fail_with(ERR_EARLY_END, r);
    if (consumed != COUNT_MAX) consumed++;

    // Chunk data passes straight through, CR and LF included
    if (ph == PH_DATA) begin
      remaining--;
      if (remaining == 0) begin
        ln = '0;
        ph = PH_TERM;
      end
      r.kind      = KIND_DATA;
      r.body_byte = b;
      return 1'b1;
    end

    // A CR must be followed by LF; the pair closes the current line
    if (ln.pending_cr) begin
      if (b != CH_LF) return fail_with(ERR_MALFORMED, r);
      ln.pending_cr = 1'b0;
      case (ph)
        PH_SIZE, PH_EXT: begin
          if (ln.bad || !ln.digit_seen) return fail_with(ERR_MALFORMED, r);
          ln = '0;
          ph = (remaining == 0) ? PH_TNAME : PH_DATA;
        end
        PH_TERM: begin
          if (ln.nonempty) return fail_with(ERR_MALFORMED, r);
          boundary  = consumed;
          ln        = '0;
          remaining = '0;
          ph        = PH_SIZE;
        end
        PH_TNAME: begin
          if (ln.nonempty) return fail_with(ERR_MALFORMED, r);
          ph           = PH_DONE;
          r.kind       = KIND_DONE;
          r.byte_count = consumed;
          return 1'b1;
        end
        default: begin
          if (ln.bad) return fail_with(ERR_MALFORMED, r);
          ln = '0;
          ph = PH_TNAME;
        end
      endcase
      return 1'b0;
    end
    if (b == CH_CR) begin
      ln.pending_cr = 1'b1;
      return 1'b0;
    end

    case (ph)
      PH_SIZE: begin
        hv = hex_nibble(b);
        if (b == CH_SEMI) begin
          ph = PH_EXT;
        end else if (hv >= 0) begin
          // Flag a digit after a blank, or one that would push bits out the top
          if (ln.blank_seen || remaining[SIZE_WIDTH-1 -: 4] != 0) begin
            ln.bad = 1'b1;
          end else begin
            remaining = {remaining[SIZE_WIDTH-5:0], 4'(hv)};
          end
          ln.digit_seen = 1'b1;
        end else if (b == CH_SPACE || b == CH_TAB) begin
          if (!ln.digit_seen) ln.bad = 1'b1;
          ln.blank_seen = 1'b1;
        end else begin
          ln.bad = 1'b1;
        end
      end
      PH_EXT: ;
      PH_TERM: ln.nonempty = 1'b1;
      PH_TNAME: begin
        if (b == CH_COLON) begin
          if (!ln.nonempty) ln.bad = 1'b1;
          ln.nonempty = 1'b1;
          ph          = PH_TVALUE;
        end else begin
          ln.nonempty = 1'b1;
          if (!is_tchar(b)) ln.bad = 1'b1;
        end
      end
      default: if (b == CH_LF || b == CH_NUL) ln.bad = 1'b1;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders: append raw bytes of the message to body_q
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    pend_item_t p;
    p.item.mode      = MODE_BYTE;
    p.item.data_byte = b;
    p.hold           = hold_next;
    hold_next        = 1'b0;
    body_q           = {body_q, p};
  endtask

  task automatic send_end();
    pend_item_t p;
    p.item.mode      = MODE_END;
    p.item.data_byte = 8'($urandom);
    p.hold           = 1'b0;
    body_q           = {body_q, p};
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Size line in mixed-case hex, with random leading zeros, trailing blanks
  // and an extension of arbitrary bytes short of CR
  task automatic send_size_line(input logic [63:0] v);
    int         top;
    logic [3:0] nib;
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 20)) send_byte("0");
    top = 15;
    while (top > 0 && v[top*4 +: 4] == 0) top--;
    for (int i = top; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 10) c = 8'h30 + nib;
      else c = 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 10);
      send_byte(c);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_byte(CH_SEMI);
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom); while (c == CH_CR);
        send_byte(c);
      end
    end
    send_crlf();
  endtask

  task automatic send_chunk(input int unsigned size);
    send_size_line(64'(size));
    repeat (size) send_byte(8'($urandom));
    send_crlf();
  endtask

  task automatic send_trailer();
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) begin
      do c = 8'($urandom_range(33, 126)); while (!is_tchar(c));
      send_byte(c);
    end
    send_byte(CH_COLON);
    repeat ($urandom_range(0, 8)) begin
      do c = 8'($urandom); while (c == CH_LF || c == CH_NUL || c == CH_CR);
      send_byte(c);
    end
    send_crlf();
  endtask

  // Close the message one way, picked at random: clean finish, early end,
  // or one of the framing faults. Then add a few items the decoder must drop.
  task automatic send_tail();
    int          n;
    logic [7:0]  c;
    logic [63:0] big;
    pend_item_t  p;
    case ($urandom_range(0, 7))
      0, 1: begin
        send_size_line(64'd0);
        repeat ($urandom_range(0, 3)) send_trailer();
        send_crlf();
      end
      2: begin
        // Cut a complete ending short anywhere, then end the input
        n = body_q.size();
        send_chunk($urandom_range(1, 8));
        send_size_line(64'd0);
        send_trailer();
        send_crlf();
        repeat ($urandom_range(1, body_q.size() - n)) void'(body_q.pop_back());
        send_end();
      end
      3: begin
        case ($urandom_range(0, 4))
          0: send_text("g");
          1: send_text(" 1");
          2: send_text("1 1");
          3: begin
            send_text("1");
            repeat (16) send_text("0");
          end
          default: ;
        endcase
        // A bad line cut off before its CRLF reports early end instead
        if ($urandom_range(0, 3) == 0) send_end();
        else send_crlf();
      end
      4: begin
        send_size_line(64'd3);
        repeat (3) send_byte(8'($urandom));
        send_text("x");
        send_crlf();
      end
      5: begin
        send_size_line(64'd0);
        repeat ($urandom_range(0, 2)) send_trailer();
        case ($urandom_range(0, 2))
          0: send_text(":v");
          1: send_text("a b:c");
          default: begin
            send_text("N:v");
            send_byte(CH_NUL);
          end
        endcase
        if ($urandom_range(0, 3) == 0) send_end();
        else send_crlf();
      end
      6: begin
        if ($urandom_range(0, 1)) begin
          send_text("1");
        end else begin
          send_size_line(64'd0);
          send_text("X");
        end
        send_byte(CH_CR);
        do c = 8'($urandom); while (c == CH_LF);
        send_byte(c);
      end
      default: begin
        // Size at the top of the 64-bit range; input runs out mid-chunk
        big          = {$urandom, $urandom};
        big[63:60]   = 4'($urandom_range(1, 15));
        send_size_line(big);
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
        send_end();
      end
    endcase
    repeat ($urandom_range(3, 6)) begin
      p.item.mode      = 1'($urandom_range(0, 1));
      p.item.data_byte = 8'($urandom);
      p.hold           = 1'b0;
      body_q           = {body_q, p};
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, some bursts back to
  // back. Change inputs on the falling edge only.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (body_q.size() > 0 && !(body_q[0].hold && decoded_q.size() > 0)) begin
          pend = body_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.mode      <= pend.item.mode;
          in_if.data_byte <= pend.item.data_byte;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: the stall pattern steps in turn between always
  // ready, coin flips, one cycle in four, and rare long stalls.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (rst_ni) begin
      rdy_cycle++;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        case (rdy_cycle[8:7])
          2'd0: rdy = 1'b1;
          2'd1: rdy = 1'($urandom_range(0, 1));
          2'd2: rdy = (rdy_cycle[1:0] == 2'd0);
          default: begin
            if ($urandom_range(0, 15) == 0) begin
              stall_left = $urandom_range(5, 20);
              rdy        = 1'b0;
            end
          end
        endcase
      end
      out_if.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Check arriving result items first, then predict for the input item taken
  // at this edge, so a same-edge push never meets a same-edge pop.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual kind %0d byte %0h",
                   $time, out_if.kind, out_if.body_byte);
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_if.kind));
          check_field("body_byte", 32'(want.body_byte), 32'(out_if.body_byte));
          check_field("error_code", 32'(want.error_code), 32'(out_if.error_code));
          check_field("byte_count", want.byte_count, out_if.byte_count);
        end
      end
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        accepted_cnt++;
        if (chunk_decode_step('{mode: in_if.mode, data_byte: in_if.data_byte}, predicted))
          decoded_q = {decoded_q, predicted};
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Build the message, reset once, then wait for everything to drain
  // --------------------------------------------------------------------------
  initial begin
    int k;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_BYTE;
    in_if.data_byte  = 8'h00;
    out_if.ready     = 1'b0;
    hold_next        = 1'b0;
    accepted_cnt     = 0;
    errors           = 0;
    cycles           = 0;
    burst_left       = 0;
    gap_left         = 0;
    stall_left       = 0;
    rdy_cycle        = 0;
    ph               = PH_SIZE;
    remaining        = '0;
    ln               = '0;
    consumed         = '0;
    boundary         = '0;

    // Directed: byte extremes, blanks and extension after the size, leading
    // zeros, CR and LF inside chunk data
    send_text("1");
    send_crlf();
    send_byte(8'h00);
    send_crlf();
    send_text("2 ");
    send_byte(CH_TAB);
    send_text(";x");
    send_crlf();
    send_byte(8'hff);
    send_byte(CH_LF);
    send_crlf();
    send_text("0001");
    send_crlf();
    send_byte(CH_CR);
    send_crlf();

    // Random chunks of mostly small sizes; let the pipe run dry once
    k = 0;
    while (body_q.size() < 680) begin
      if (k == 10) hold_next = 1'b1;
      send_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                             : $urandom_range(1, 40));
      k++;
    end
    send_tail();
    total_items = body_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (accepted_cnt != total_items);
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
